>>> rtl/sbsl_pkg.sv
// Shared types, constants and arithmetic helpers for the servo bank slew limiter.
// No dependencies; used by sbsl_ctrl, sbsl_dp and servo_bank_slew_limiter_unit.
`default_nettype none

package sbsl_pkg;

    localparam int MAX_SERVOS_DEF = 8;

    localparam int ANG_MIN   = -125;
    localparam int ANG_MAX   = 125;
    localparam int TRIM_MIN  = -25;
    localparam int TRIM_MAX  = 25;
    localparam int CENTER    = 150;
    localparam int DRIVE_MAX = 300;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SET    = 3'd1,
        OP_NUDGE  = 3'd2,
        OP_READ   = 3'd3,
        OP_TICK   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_DRIVE   = 2'd0,
        KIND_ADDED   = 2'd1,
        KIND_REFUSED = 2'd2,
        KIND_PRESENT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVAL,
        ST_MISS,
        ST_LAST
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_TARGET_SET,
        WR_TARGET_NUDGE,
        WR_NEW,
        WR_CURRENT
    } t_wr;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_REFUSED,
        PEND_READ_HIT,
        PEND_READ_MISS,
        PEND_ADDED,
        PEND_MOVED
    } t_pend;

    // Input item, op in the lowest bits
    typedef struct packed {
        logic [3:0]         step;
        logic signed [5:0]  trim;
        logic signed [15:0] angle;
        logic [7:0]         id;
        logic [2:0]         op;
    } t_item;

    typedef struct packed {
        logic [7:0]        id;
        logic signed [5:0] trim;
        logic [3:0]        step;
        logic signed [7:0] current;
        logic signed [7:0] target;
    } t_entry;

    typedef struct packed {
        logic  accept;
        logic  clear;
        logic  rd;
        logic  idx_inc;
        t_wr   wr;
        t_pend pend;
        logic  push;
        logic  push_last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic used_zero;
        logic idx_at_end;
        logic full;
        logic hit;
        logic moved;
        logic out_free;
        logic pend_valid;
    } t_status;

    function automatic logic signed [7:0] clamp_angle(input logic signed [16:0] v);
        logic signed [7:0] r;
        if (v < ANG_MIN) begin
            r = 8'(ANG_MIN);
        end else if (v > ANG_MAX) begin
            r = 8'(ANG_MAX);
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic signed [5:0] clamp_trim(input logic signed [5:0] v);
        logic signed [5:0] r;
        if (v < TRIM_MIN) begin
            r = 6'(TRIM_MIN);
        end else if (v > TRIM_MAX) begin
            r = 6'(TRIM_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [8:0] drive_of(input logic signed [7:0] cur,
                                            input logic signed [5:0] trim);
        logic signed [9:0] s;
        logic [8:0]        r;
        s = 10'(cur) + 10'(trim) + 10'(CENTER);
        if (s < 0) begin
            r = '0;
        end else if (s > DRIVE_MAX) begin
            r = 9'(DRIVE_MAX);
        end else begin
            r = s[8:0];
        end
        return r;
    endfunction

    // Move cur toward tgt by at most step
    function automatic logic signed [7:0] step_toward(input logic signed [7:0] cur,
                                                      input logic signed [7:0] tgt,
                                                      input logic [3:0]        step);
        logic signed [8:0] d;
        logic signed [8:0] st;
        logic signed [8:0] s;
        d  = 9'(tgt) - 9'(cur);
        st = $signed({5'b0, step});
        if (d > st) begin
            d = st;
        end else if (d < -st) begin
            d = -st;
        end
        s = 9'(cur) + d;
        return s[7:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/sbsl_ctrl.sv
// Sequencer for the servo bank slew limiter: walks the table per operation.
// Depends on sbsl_pkg; drives sbsl_dp through t_cmd, reads t_status back.
`default_nettype none

module sbsl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire sbsl_pkg::t_status i_stat,
    output logic                o_in_ready,
    output sbsl_pkg::t_cmd      o_cmd
);

    sbsl_pkg::t_state r_state;
    sbsl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbsl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbsl_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sbsl_pkg::ST_START;
            end
            sbsl_pkg::ST_START: begin
                case (i_stat.op)
                    sbsl_pkg::OP_CLEAR: n_state = sbsl_pkg::ST_IDLE;
                    sbsl_pkg::OP_TICK:
                        n_state = i_stat.used_zero ? sbsl_pkg::ST_IDLE : sbsl_pkg::ST_READ;
                    sbsl_pkg::OP_ADD, sbsl_pkg::OP_SET,
                    sbsl_pkg::OP_NUDGE, sbsl_pkg::OP_READ:
                        n_state = i_stat.used_zero ? sbsl_pkg::ST_MISS : sbsl_pkg::ST_READ;
                    default: n_state = sbsl_pkg::ST_IDLE;
                endcase
            end
            sbsl_pkg::ST_READ: n_state = sbsl_pkg::ST_EVAL;
            sbsl_pkg::ST_EVAL: begin
                if (i_stat.op == sbsl_pkg::OP_TICK) begin
                    if (!i_stat.moved || !i_stat.pend_valid || i_stat.out_free) begin
                        n_state = i_stat.idx_at_end ? sbsl_pkg::ST_LAST : sbsl_pkg::ST_READ;
                    end
                end else if (i_stat.hit) begin
                    case (i_stat.op)
                        sbsl_pkg::OP_ADD, sbsl_pkg::OP_READ: n_state = sbsl_pkg::ST_LAST;
                        default:                             n_state = sbsl_pkg::ST_IDLE;
                    endcase
                end else begin
                    n_state = i_stat.idx_at_end ? sbsl_pkg::ST_MISS : sbsl_pkg::ST_READ;
                end
            end
            sbsl_pkg::ST_MISS: begin
                case (i_stat.op)
                    sbsl_pkg::OP_ADD, sbsl_pkg::OP_READ: n_state = sbsl_pkg::ST_LAST;
                    default:                             n_state = sbsl_pkg::ST_IDLE;
                endcase
            end
            sbsl_pkg::ST_LAST: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = sbsl_pkg::ST_IDLE;
            end
            default: n_state = sbsl_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.accept      = 1'b0;
        o_cmd.clear       = 1'b0;
        o_cmd.rd          = 1'b0;
        o_cmd.idx_inc     = 1'b0;
        o_cmd.wr          = sbsl_pkg::WR_NONE;
        o_cmd.pend        = sbsl_pkg::PEND_NONE;
        o_cmd.push        = 1'b0;
        o_cmd.push_last   = 1'b0;
        case (r_state)
            sbsl_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            sbsl_pkg::ST_START: begin
                o_cmd.clear = (i_stat.op == sbsl_pkg::OP_CLEAR);
            end
            sbsl_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            sbsl_pkg::ST_EVAL: begin
                if (i_stat.op == sbsl_pkg::OP_TICK) begin
                    if (!i_stat.moved || !i_stat.pend_valid || i_stat.out_free) begin
                        o_cmd.idx_inc = !i_stat.idx_at_end;
                        if (i_stat.moved) begin
                            o_cmd.push = i_stat.pend_valid;
                            o_cmd.pend = sbsl_pkg::PEND_MOVED;
                            o_cmd.wr   = sbsl_pkg::WR_CURRENT;
                        end
                    end
                end else if (i_stat.hit) begin
                    case (i_stat.op)
                        sbsl_pkg::OP_ADD:   o_cmd.pend = sbsl_pkg::PEND_REFUSED;
                        sbsl_pkg::OP_SET:   o_cmd.wr   = sbsl_pkg::WR_TARGET_SET;
                        sbsl_pkg::OP_NUDGE: o_cmd.wr   = sbsl_pkg::WR_TARGET_NUDGE;
                        sbsl_pkg::OP_READ:  o_cmd.pend = sbsl_pkg::PEND_READ_HIT;
                        default:            o_cmd.pend = sbsl_pkg::PEND_NONE;
                    endcase
                end else begin
                    o_cmd.idx_inc = !i_stat.idx_at_end;
                end
            end
            sbsl_pkg::ST_MISS: begin
                case (i_stat.op)
                    sbsl_pkg::OP_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.pend = sbsl_pkg::PEND_REFUSED;
                        end else begin
                            o_cmd.pend = sbsl_pkg::PEND_ADDED;
                            o_cmd.wr   = sbsl_pkg::WR_NEW;
                        end
                    end
                    sbsl_pkg::OP_READ: o_cmd.pend = sbsl_pkg::PEND_READ_MISS;
                    default:           o_cmd.pend = sbsl_pkg::PEND_NONE;
                endcase
            end
            sbsl_pkg::ST_LAST: begin
                o_cmd.push      = i_stat.pend_valid && i_stat.out_free;
                o_cmd.push_last = 1'b1;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sbsl_dp.sv
// Datapath of the servo bank slew limiter: servo table memory, item register,
// pending result and output register. Depends on sbsl_pkg; steered by sbsl_ctrl.
`default_nettype none

module sbsl_dp #(
    parameter int MAX_SERVOS = sbsl_pkg::MAX_SERVOS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [sbsl_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  wire sbsl_pkg::t_cmd                     i_cmd,
    input  wire logic                               i_out_ready,
    output sbsl_pkg::t_status                       o_stat,
    output logic                                    o_out_valid,
    output logic [sbsl_pkg::OUT_TDATA_W-1:0]        o_out_data,
    output logic [1:0]                              o_out_kind,
    output logic                                    o_out_last
);

    localparam int IDX_W = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
    localparam int CNT_W = $clog2(MAX_SERVOS + 1);

    sbsl_pkg::t_item   r_item;
    sbsl_pkg::t_entry  r_mem [MAX_SERVOS];
    sbsl_pkg::t_entry  r_rd;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_used;

    logic              r_pend_valid;
    sbsl_pkg::t_kind   r_pend_kind;
    logic [7:0]        r_pend_id;
    logic signed [7:0] r_pend_cur;
    logic signed [5:0] r_pend_trim;

    logic              r_out_valid;
    sbsl_pkg::t_kind   r_out_kind;
    logic [7:0]        r_out_id;
    logic [8:0]        r_out_drive;
    logic signed [7:0] r_out_present;
    logic              r_out_last;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    sbsl_pkg::t_entry  mem_wdata;
    logic [CNT_W-1:0]  idx_next;
    logic signed [7:0] add_angle;
    logic signed [5:0] add_trim;
    logic signed [7:0] tick_cur;
    logic              out_free;

    assign idx_next  = CNT_W'(r_idx) + 1'b1;
    assign add_angle = sbsl_pkg::clamp_angle(17'(r_item.angle));
    assign add_trim  = sbsl_pkg::clamp_trim(r_item.trim);
    assign tick_cur  = sbsl_pkg::step_toward(r_rd.current, r_rd.target, r_rd.step);
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.op         = sbsl_pkg::t_op'(r_item.op);
    assign o_stat.used_zero  = (r_used == '0);
    assign o_stat.idx_at_end = (idx_next >= r_used);
    assign o_stat.full       = (r_used == CNT_W'(MAX_SERVOS));
    assign o_stat.hit        = (r_rd.id == r_item.id);
    assign o_stat.moved      = (r_rd.current != r_rd.target);
    assign o_stat.out_free   = out_free;
    assign o_stat.pend_valid = r_pend_valid;

    // table write port
    always_comb begin
        mem_we    = 1'b1;
        mem_waddr = r_idx;
        mem_wdata = r_rd;
        case (i_cmd.wr)
            sbsl_pkg::WR_TARGET_SET: begin
                mem_wdata.target = add_angle;
            end
            sbsl_pkg::WR_TARGET_NUDGE: begin
                mem_wdata.target =
                    sbsl_pkg::clamp_angle(17'(r_rd.target) + 17'(r_item.angle));
            end
            sbsl_pkg::WR_CURRENT: begin
                mem_wdata.current = tick_cur;
            end
            sbsl_pkg::WR_NEW: begin
                mem_waddr         = r_used[IDX_W-1:0];
                mem_wdata.id      = r_item.id;
                mem_wdata.trim    = add_trim;
                mem_wdata.step    = (r_item.step == '0) ? 4'd1 : r_item.step;
                mem_wdata.current = add_angle;
                mem_wdata.target  = add_angle;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_cmd.rd) r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= sbsl_pkg::t_item'(i_in_data[$bits(sbsl_pkg::t_item)-1:0]);
        if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.clear) begin
            r_used <= '0;
        end else if (i_cmd.wr == sbsl_pkg::WR_NEW) begin
            r_used <= r_used + 1'b1;
        end
    end

    // pending result: held back one slot so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pend != sbsl_pkg::PEND_NONE) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.push || i_cmd.accept) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.pend)
            sbsl_pkg::PEND_REFUSED: begin
                r_pend_kind <= sbsl_pkg::KIND_REFUSED;
                r_pend_id   <= r_item.id;
                r_pend_cur  <= '0;
                r_pend_trim <= '0;
            end
            sbsl_pkg::PEND_READ_HIT: begin
                r_pend_kind <= sbsl_pkg::KIND_PRESENT;
                r_pend_id   <= r_item.id;
                r_pend_cur  <= r_rd.current;
                r_pend_trim <= '0;
            end
            sbsl_pkg::PEND_READ_MISS: begin
                r_pend_kind <= sbsl_pkg::KIND_PRESENT;
                r_pend_id   <= r_item.id;
                r_pend_cur  <= '0;
                r_pend_trim <= '0;
            end
            sbsl_pkg::PEND_ADDED: begin
                r_pend_kind <= sbsl_pkg::KIND_ADDED;
                r_pend_id   <= r_item.id;
                r_pend_cur  <= add_angle;
                r_pend_trim <= add_trim;
            end
            sbsl_pkg::PEND_MOVED: begin
                r_pend_kind <= sbsl_pkg::KIND_DRIVE;
                r_pend_id   <= r_rd.id;
                r_pend_cur  <= tick_cur;
                r_pend_trim <= r_rd.trim;
            end
            default: begin
                r_pend_kind <= r_pend_kind;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_kind <= r_pend_kind;
            r_out_id   <= r_pend_id;
            r_out_last <= i_cmd.push_last;
            if (r_pend_kind == sbsl_pkg::KIND_DRIVE || r_pend_kind == sbsl_pkg::KIND_ADDED) begin
                r_out_drive <= sbsl_pkg::drive_of(r_pend_cur, r_pend_trim);
            end else begin
                r_out_drive <= '0;
            end
            r_out_present <= (r_pend_kind == sbsl_pkg::KIND_PRESENT) ? r_pend_cur : 8'sd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {7'b0, r_out_present, r_out_drive, r_out_id};

endmodule

`default_nettype wire

>>> rtl/servo_bank_slew_limiter_unit.sv
// Top level of the servo bank slew limiter: stream ports, sequencer and datapath.
// Depends on sbsl_pkg, sbsl_ctrl and sbsl_dp.
//
//  Channel   Dir  Signals                      Carries
//  s_axis    in   tvalid tready tdata[39:0]    op, servo_id, angle_value, trim_offset, step_size
//  m_axis    out  tvalid tready tdata[31:0]    out_id, drive_angle, present_angle
//                 tuser[1:0] tlast             kind, last result of the item
//
// One item at a time. Each table entry visited takes a memory read, then an
// evaluate step; handing out results does not slow the walk unless m_axis
// stalls. The table memory sets this pace.
// Reset (i_rst_n low at a clock edge) empties the table; entries are not cleared.
// A stalled m_axis side holds the walk in place; s_axis stays low-ready until
// the item's last result sits in the output register.
`default_nettype none

module servo_bank_slew_limiter_unit #(
    parameter int MAX_SERVOS = sbsl_pkg::MAX_SERVOS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [2:0] op, [10:3] servo_id, [26:11] angle_value, [32:27] trim_offset,
    // [36:33] step_size, [39:37] zero
    input  wire logic [sbsl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] out_id, [16:8] drive_angle, [24:17] present_angle, [31:25] zero
    output logic [sbsl_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);

    sbsl_pkg::t_cmd    cmd;
    sbsl_pkg::t_status stat;

    // sequencer: decides which entry to visit and what to write or report
    sbsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // table, arithmetic and result registers
    sbsl_dp #(
        .MAX_SERVOS (MAX_SERVOS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
